[src/lome_pkg.sv]
`default_nettype none
package lome_pkg;

    // Slot index and rank width; covers books of up to 63 slots.
    localparam int SLOT_IW = 6;
    localparam int CNT_W   = 6;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [2:0] ST_RESTING   = 3'd0;
    localparam logic [2:0] ST_PARTIAL   = 3'd1;
    localparam logic [2:0] ST_FILLED    = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic [2:0] RJ_NONE      = 3'd0;
    localparam logic [2:0] RJ_UNKNOWN   = 3'd1;
    localparam logic [2:0] RJ_BAD_PRICE = 3'd2;
    localparam logic [2:0] RJ_BAD_QTY   = 3'd3;
    localparam logic [2:0] RJ_DUPLICATE = 3'd4;
    localparam logic [2:0] RJ_BOOK_FULL = 3'd5;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_FILL,
        OP_REMOVE,
        OP_INSERT
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_MSTART,
        S_MWAIT,
        S_MDO,
        S_REPORT
    } t_state;

    // Record that walks down the cell chain during a book scan.
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [SLOT_IW-1:0] hit_idx;
        logic               hit_side;
        logic [30:0]        hit_price;
        logic [31:0]        hit_filled;
        logic [CNT_W-1:0]   hit_arr;
        logic               free;
        logic [SLOT_IW-1:0] free_idx;
        logic [CNT_W-1:0]   cnt;
        logic               best;
        logic [SLOT_IW-1:0] b_idx;
        logic [30:0]        b_price;
        logic [CNT_W-1:0]   b_arr;
        logic [31:0]        b_id;
        logic [31:0]        b_rem;
    } t_scan;

    typedef struct packed {
        logic [31:0] id;
        logic        msd;
    } t_key;

    // Book update broadcast to every cell.
    typedef struct packed {
        t_op                op;
        logic [SLOT_IW-1:0] idx;
        logic [31:0]        qty;
        logic [CNT_W-1:0]   rank;
        logic               drop;
        logic [31:0]        id;
        logic               side;
        logic [30:0]        price;
        logic [31:0]        filled;
    } t_cmd;

    typedef struct packed {
        logic        is_report;
        logic        last_item;
        logic [31:0] subject_id;
        logic [31:0] maker_ident;
        logic        side_out;
        logic [31:0] price_out;
        logic [31:0] qty_out;
        logic [31:0] filled_total;
        logic [2:0]  status_code;
        logic [2:0]  reject_code;
        logic [31:0] seq_out;
        logic [31:0] trade_number;
    } t_res;

endpackage
`default_nettype wire

[src/limit_order_matching_engine_top.sv]
// Flow: an item passes its field checks on acceptance; each book lookup is one scan
// down the chain of BOOK_SLOTS cells. A field reject goes straight to its report; a
// cancel or lookup reject takes only the lookup scan; a create or modify that reaches
// matching takes the lookup scan, then one rescan before each fill or rest decision.
// Only one item is in the block at a time; output stalls can hold it up.
// Reset (synchronous, active low): book empty, sequence and trade counters at one,
// output register empty.
`default_nettype none
module limit_order_matching_engine_top #(
    parameter int BOOK_SLOTS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // command items
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [1:0]          i_req_type,
    input  wire  [31:0]         i_seq_in,
    input  wire  [31:0]         i_order_ident,
    input  wire                 i_buy_sell,
    input  wire  signed [31:0]  i_limit_price,
    input  wire  [31:0]         i_order_qty,
    // result items: trades then one final report
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_is_report,
    output logic                o_last_item,
    output logic [31:0]         o_subject_id,
    output logic [31:0]         o_maker_ident,
    output logic                o_side_out,
    output logic signed [31:0]  o_price_out,
    output logic [31:0]         o_qty_out,
    output logic [31:0]         o_filled_total,
    output logic [2:0]          o_status_code,
    output logic [2:0]          o_reject_code,
    output logic [31:0]         o_seq_out,
    output logic [31:0]         o_trade_number
);
    // Each cell holds one slot. A scan record enters cell 0 and moves one cell per
    // cycle, picking up the id match, the lowest free slot, the valid count and
    // the best opposite order (price, then age rank).
    lome_pkg::t_scan w_scan [BOOK_SLOTS+1];
    lome_pkg::t_key  w_key;
    lome_pkg::t_cmd  w_cmd;
    lome_pkg::t_res  w_res;

    genvar g;
    generate
        for (g = 0; g < BOOK_SLOTS; g++) begin : g_cell
            lome_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_scan  (w_scan[g]),
                .o_scan  (w_scan[g+1]),
                .i_key   (w_key),
                .i_cmd   (w_cmd)
            );
        end
    endgenerate

    // Sequencer: checks, match loop, and the output register that lets the
    // result wait while the next command is taken.
    lome_ctrl #(
        .N (BOOK_SLOTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_seq_in      (i_seq_in),
        .i_order_ident (i_order_ident),
        .i_buy_sell    (i_buy_sell),
        .i_limit_price (i_limit_price),
        .i_order_qty   (i_order_qty),
        .o_scan_go     (w_scan[0]),
        .i_scan_tail   (w_scan[BOOK_SLOTS]),
        .o_key         (w_key),
        .o_cmd         (w_cmd),
        .o_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .o_res         (w_res)
    );

    assign o_is_report    = w_res.is_report;
    assign o_last_item    = w_res.last_item;
    assign o_subject_id   = w_res.subject_id;
    assign o_maker_ident  = w_res.maker_ident;
    assign o_side_out     = w_res.side_out;
    assign o_price_out    = w_res.price_out;
    assign o_qty_out      = w_res.qty_out;
    assign o_filled_total = w_res.filled_total;
    assign o_status_code  = w_res.status_code;
    assign o_reject_code  = w_res.reject_code;
    assign o_seq_out      = w_res.seq_out;
    assign o_trade_number = w_res.trade_number;

endmodule
`default_nettype wire

[src/lome_cell.sv]
`default_nettype none
// One book slot plus one stage of the scan chain.
module lome_cell #(
    parameter int IDX = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  lome_pkg::t_scan     i_scan,
    output lome_pkg::t_scan     o_scan,
    input  lome_pkg::t_key      i_key,
    input  lome_pkg::t_cmd      i_cmd
);
    localparam logic [lome_pkg::SLOT_IW-1:0] MY = IDX[lome_pkg::SLOT_IW-1:0];

    logic                        r_valid;
    logic [31:0]                 r_id;
    logic                        r_side;
    logic [30:0]                 r_price;
    logic [31:0]                 r_rem;
    logic [31:0]                 r_filled;
    logic [lome_pkg::CNT_W-1:0]  r_arr;
    lome_pkg::t_scan             r_scan;
    lome_pkg::t_scan             n_scan;
    logic                        w_better;
    logic                        w_mine;
    logic                        w_older;

    assign w_mine  = (i_cmd.idx == MY);
    assign w_older = r_valid && (r_arr > i_cmd.rank);

    always_comb begin
        if (!i_scan.best) begin
            w_better = 1'b1;
        end else if (r_price == i_scan.b_price) begin
            w_better = r_arr < i_scan.b_arr;
        end else if (i_key.msd) begin
            w_better = r_price < i_scan.b_price;
        end else begin
            w_better = r_price > i_scan.b_price;
        end
    end

    always_comb begin
        n_scan = i_scan;
        if (r_valid) begin
            n_scan.cnt = i_scan.cnt + 1'b1;
        end
        if (r_valid && r_id == i_key.id && !i_scan.hit) begin
            n_scan.hit        = 1'b1;
            n_scan.hit_idx    = MY;
            n_scan.hit_side   = r_side;
            n_scan.hit_price  = r_price;
            n_scan.hit_filled = r_filled;
            n_scan.hit_arr    = r_arr;
        end
        if (!r_valid && !i_scan.free) begin
            n_scan.free     = 1'b1;
            n_scan.free_idx = MY;
        end
        if (r_valid && r_side == i_key.msd && w_better) begin
            n_scan.best    = 1'b1;
            n_scan.b_idx   = MY;
            n_scan.b_price = r_price;
            n_scan.b_arr   = r_arr;
            n_scan.b_id    = r_id;
            n_scan.b_rem   = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.vld <= 1'b0;
        end else begin
            r_scan.vld <= n_scan.vld;
        end
        r_scan.hit        <= n_scan.hit;
        r_scan.hit_idx    <= n_scan.hit_idx;
        r_scan.hit_side   <= n_scan.hit_side;
        r_scan.hit_price  <= n_scan.hit_price;
        r_scan.hit_filled <= n_scan.hit_filled;
        r_scan.hit_arr    <= n_scan.hit_arr;
        r_scan.free       <= n_scan.free;
        r_scan.free_idx   <= n_scan.free_idx;
        r_scan.cnt        <= n_scan.cnt;
        r_scan.best       <= n_scan.best;
        r_scan.b_idx      <= n_scan.b_idx;
        r_scan.b_price    <= n_scan.b_price;
        r_scan.b_arr      <= n_scan.b_arr;
        r_scan.b_id       <= n_scan.b_id;
        r_scan.b_rem      <= n_scan.b_rem;
    end

    assign o_scan = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                lome_pkg::OP_FILL: begin
                    if (w_mine) begin
                        r_rem    <= r_rem - i_cmd.qty;
                        r_filled <= r_filled + i_cmd.qty;
                        if (i_cmd.drop) begin
                            r_valid <= 1'b0;
                        end
                    end else if (i_cmd.drop && w_older) begin
                        r_arr <= r_arr - 1'b1;
                    end
                end
                lome_pkg::OP_REMOVE: begin
                    if (w_mine) begin
                        r_valid <= 1'b0;
                    end else if (w_older) begin
                        r_arr <= r_arr - 1'b1;
                    end
                end
                lome_pkg::OP_INSERT: begin
                    if (w_mine) begin
                        r_valid  <= 1'b1;
                        r_id     <= i_cmd.id;
                        r_side   <= i_cmd.side;
                        r_price  <= i_cmd.price;
                        r_rem    <= i_cmd.qty;
                        r_filled <= i_cmd.filled;
                        r_arr    <= i_cmd.rank;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[src/lome_ctrl.sv]
`default_nettype none
// Command sequencer: checks, scan launch, fill loop, result register.
module lome_ctrl #(
    parameter int N = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [1:0]          i_req_type,
    input  wire  [31:0]         i_seq_in,
    input  wire  [31:0]         i_order_ident,
    input  wire                 i_buy_sell,
    input  wire  signed [31:0]  i_limit_price,
    input  wire  [31:0]         i_order_qty,
    output lome_pkg::t_scan     o_scan_go,
    input  lome_pkg::t_scan     i_scan_tail,
    output lome_pkg::t_key      o_key,
    output lome_pkg::t_cmd      o_cmd,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output lome_pkg::t_res      o_res
);
    localparam logic [lome_pkg::CNT_W-1:0] K_MAX = N[lome_pkg::CNT_W-1:0];

    lome_pkg::t_state            r_state, n_state;
    logic [1:0]                  r_type;
    logic [31:0]                 r_id;
    logic                        r_side, n_side;
    logic [31:0]                 r_price;
    logic [31:0]                 r_rem, n_rem;
    logic [31:0]                 r_filled, n_filled;
    logic [31:0]                 r_seq;
    logic [lome_pkg::CNT_W-1:0]  r_k, n_k;
    logic [31:0]                 r_next_seq, n_next_seq;
    logic [31:0]                 r_next_trade, n_next_trade;
    lome_pkg::t_scan             r_scan;
    lome_pkg::t_res              r_rpt, n_rpt;
    logic                        r_ov;
    lome_pkg::t_res              r_out;
    lome_pkg::t_res              n_out;
    logic                        w_push;
    logic                        w_can_push;
    logic                        w_acc;
    logic                        w_go;
    logic                        w_bad_in_price;
    logic                        w_cross;
    logic [31:0]                 w_q;
    logic [31:0]                 w_seq;

    function automatic lome_pkg::t_res mk_rpt(
        input logic [31:0] id, input logic side, input logic [31:0] price,
        input logic [31:0] qty, input logic [31:0] filled, input logic [2:0] st,
        input logic [2:0] rj, input logic [31:0] seq);
        lome_pkg::t_res r;
        r.is_report    = 1'b1;
        r.last_item    = 1'b1;
        r.subject_id   = id;
        r.maker_ident  = 32'd0;
        r.side_out     = side;
        r.price_out    = price;
        r.qty_out      = qty;
        r.filled_total = filled;
        r.status_code  = st;
        r.reject_code  = rj;
        r.seq_out      = seq;
        r.trade_number = 32'd0;
        return r;
    endfunction

    assign o_ready        = (r_state == lome_pkg::S_IDLE);
    assign w_acc          = i_valid && o_ready && (i_req_type != lome_pkg::REQ_NONE);
    assign w_can_push     = !r_ov || i_res_ready;
    assign w_bad_in_price = i_limit_price[31] || (i_limit_price == 32'sd0);
    assign w_seq          = (i_seq_in == 32'd0) ? r_next_seq : i_seq_in;
    assign w_q            = (r_rem < r_scan.b_rem) ? r_rem : r_scan.b_rem;
    assign w_cross        = r_scan.best &&
                            (r_side ? (r_price[30:0] <= r_scan.b_price)
                                    : (r_price[30:0] >= r_scan.b_price));

    // The lookup scan leaves at the accepting edge, so cell 0 sees the incoming id.
    assign o_key.id  = (r_state == lome_pkg::S_IDLE) ? i_order_ident : r_id;
    assign o_key.msd = ~r_side;

    always_comb begin
        o_scan_go     = '0;
        o_scan_go.vld = w_go;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lome_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (i_req_type == lome_pkg::REQ_CANCEL) begin
                        n_state = lome_pkg::S_FIND;
                    end else if (w_bad_in_price || i_order_qty == 32'd0 ||
                        (i_req_type == lome_pkg::REQ_CREATE && i_order_ident == 32'd0)) begin
                        n_state = lome_pkg::S_REPORT;
                    end else begin
                        n_state = lome_pkg::S_FIND;
                    end
                end
            end
            lome_pkg::S_FIND: begin
                if (i_scan_tail.vld) begin
                    n_state = lome_pkg::S_DECIDE;
                end
            end
            lome_pkg::S_DECIDE: begin
                if (r_type == lome_pkg::REQ_CANCEL || r_scan.hit == (r_type == lome_pkg::REQ_CREATE)) begin
                    n_state = lome_pkg::S_REPORT;
                end else begin
                    n_state = lome_pkg::S_MSTART;
                end
            end
            lome_pkg::S_MSTART: n_state = lome_pkg::S_MWAIT;
            lome_pkg::S_MWAIT: begin
                if (i_scan_tail.vld) begin
                    n_state = lome_pkg::S_MDO;
                end
            end
            lome_pkg::S_MDO: begin
                if (r_rem == 32'd0 || r_k == K_MAX || !w_cross) begin
                    n_state = lome_pkg::S_REPORT;
                end else if (w_can_push) begin
                    n_state = lome_pkg::S_MSTART;
                end
            end
            lome_pkg::S_REPORT: begin
                if (w_can_push) begin
                    n_state = lome_pkg::S_IDLE;
                end
            end
            default: n_state = lome_pkg::S_IDLE;
        endcase
    end

    // Datapath and book commands
    always_comb begin
        n_side       = r_side;
        n_rem        = r_rem;
        n_filled     = r_filled;
        n_k          = r_k;
        n_next_seq   = r_next_seq;
        n_next_trade = r_next_trade;
        n_rpt        = r_rpt;
        n_out        = r_out;
        w_push       = 1'b0;
        w_go         = 1'b0;
        o_cmd        = '0;
        o_cmd.op     = lome_pkg::OP_NONE;
        case (r_state)
            lome_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (i_seq_in == 32'd0) begin
                        n_next_seq = r_next_seq + 32'd1;
                    end else if (i_seq_in >= r_next_seq) begin
                        n_next_seq = i_seq_in + 32'd1;
                    end
                    n_side   = i_buy_sell;
                    n_rem    = i_order_qty;
                    n_filled = 32'd0;
                    n_k      = '0;
                    w_go     = 1'b1;
                    if (i_req_type == lome_pkg::REQ_CREATE) begin
                        if (i_order_ident == 32'd0) begin
                            n_rpt = mk_rpt(i_order_ident, i_buy_sell, i_limit_price, 32'd0,
                                           32'd0, lome_pkg::ST_REJECTED, lome_pkg::RJ_UNKNOWN, w_seq);
                        end else if (w_bad_in_price) begin
                            n_rpt = mk_rpt(i_order_ident, i_buy_sell, i_limit_price, 32'd0,
                                           32'd0, lome_pkg::ST_REJECTED, lome_pkg::RJ_BAD_PRICE, w_seq);
                        end else begin
                            n_rpt = mk_rpt(i_order_ident, i_buy_sell, i_limit_price, 32'd0,
                                           32'd0, lome_pkg::ST_REJECTED, lome_pkg::RJ_BAD_QTY, w_seq);
                        end
                    end else if (i_req_type == lome_pkg::REQ_MODIFY) begin
                        if (w_bad_in_price) begin
                            n_rpt = mk_rpt(i_order_ident, 1'b0, i_limit_price, 32'd0, 32'd0,
                                           lome_pkg::ST_REJECTED, lome_pkg::RJ_BAD_PRICE, w_seq);
                        end else begin
                            n_rpt = mk_rpt(i_order_ident, 1'b0, i_limit_price, 32'd0, 32'd0,
                                           lome_pkg::ST_REJECTED, lome_pkg::RJ_BAD_QTY, w_seq);
                        end
                    end
                end
            end
            lome_pkg::S_DECIDE: begin
                case (r_type)
                    lome_pkg::REQ_CREATE: begin
                        n_rpt = mk_rpt(r_id, r_side, r_price, 32'd0, 32'd0,
                                       lome_pkg::ST_REJECTED, lome_pkg::RJ_DUPLICATE, r_seq);
                    end
                    lome_pkg::REQ_CANCEL: begin
                        if (r_scan.hit) begin
                            n_rpt = mk_rpt(r_id, r_scan.hit_side, {1'b0, r_scan.hit_price},
                                           32'd0, r_scan.hit_filled, lome_pkg::ST_CANCELLED,
                                           lome_pkg::RJ_NONE, r_seq);
                        end else begin
                            n_rpt = mk_rpt(r_id, 1'b0, 32'd0, 32'd0, 32'd0,
                                           lome_pkg::ST_REJECTED, lome_pkg::RJ_UNKNOWN, r_seq);
                        end
                    end
                    default: begin
                        n_side = r_scan.hit_side;
                        n_rpt  = mk_rpt(r_id, 1'b0, r_price, 32'd0, 32'd0,
                                        lome_pkg::ST_REJECTED, lome_pkg::RJ_UNKNOWN, r_seq);
                    end
                endcase
                if (r_type != lome_pkg::REQ_CREATE && r_scan.hit) begin
                    o_cmd.op   = lome_pkg::OP_REMOVE;
                    o_cmd.idx  = r_scan.hit_idx;
                    o_cmd.rank = r_scan.hit_arr;
                end
            end
            lome_pkg::S_MSTART: begin
                w_go = 1'b1;
            end
            lome_pkg::S_MDO: begin
                if (r_rem == 32'd0) begin
                    n_rpt = mk_rpt(r_id, r_side, r_price, 32'd0, r_filled,
                                   lome_pkg::ST_FILLED, lome_pkg::RJ_NONE, r_seq);
                end else if (r_k == K_MAX || !w_cross) begin
                    if (!r_scan.free) begin
                        n_rpt = mk_rpt(r_id, r_side, r_price, r_rem, r_filled,
                                       lome_pkg::ST_REJECTED, lome_pkg::RJ_BOOK_FULL, r_seq);
                    end else begin
                        n_rpt = mk_rpt(r_id, r_side, r_price, r_rem, r_filled,
                                       (r_k == '0) ? lome_pkg::ST_RESTING : lome_pkg::ST_PARTIAL,
                                       lome_pkg::RJ_NONE, r_seq);
                        o_cmd.op     = lome_pkg::OP_INSERT;
                        o_cmd.idx    = r_scan.free_idx;
                        o_cmd.rank   = r_scan.cnt;
                        o_cmd.qty    = r_rem;
                        o_cmd.id     = r_id;
                        o_cmd.side   = r_side;
                        o_cmd.price  = r_price[30:0];
                        o_cmd.filled = r_filled;
                    end
                end else if (w_can_push) begin
                    w_push             = 1'b1;
                    n_out.is_report    = 1'b0;
                    n_out.last_item    = 1'b0;
                    n_out.subject_id   = r_id;
                    n_out.maker_ident  = r_scan.b_id;
                    n_out.side_out     = ~r_side;
                    n_out.price_out    = {1'b0, r_scan.b_price};
                    n_out.qty_out      = w_q;
                    n_out.filled_total = 32'd0;
                    n_out.status_code  = lome_pkg::ST_RESTING;
                    n_out.reject_code  = lome_pkg::RJ_NONE;
                    n_out.seq_out      = r_seq;
                    n_out.trade_number = r_next_trade;
                    o_cmd.op   = lome_pkg::OP_FILL;
                    o_cmd.idx  = r_scan.b_idx;
                    o_cmd.qty  = w_q;
                    o_cmd.rank = r_scan.b_arr;
                    o_cmd.drop = (w_q == r_scan.b_rem);
                    n_rem        = r_rem - w_q;
                    n_filled     = r_filled + w_q;
                    n_k          = r_k + 1'b1;
                    n_next_trade = r_next_trade + 32'd1;
                end
            end
            lome_pkg::S_REPORT: begin
                if (w_can_push) begin
                    w_push = 1'b1;
                    n_out  = r_rpt;
                end
            end
            default: begin
            end
        endcase
        // A create or modify rejected on its fields never launches a scan.
        if (r_state == lome_pkg::S_IDLE && n_state == lome_pkg::S_REPORT) begin
            w_go = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lome_pkg::S_IDLE;
            r_next_seq   <= 32'd1;
            r_next_trade <= 32'd1;
            r_ov         <= 1'b0;
            r_k          <= '0;
        end else begin
            r_state      <= n_state;
            r_next_seq   <= n_next_seq;
            r_next_trade <= n_next_trade;
            r_k          <= n_k;
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_type  <= i_req_type;
            r_id    <= i_order_ident;
            r_price <= i_limit_price;
            r_seq   <= w_seq;
        end
        if (i_scan_tail.vld) begin
            r_scan <= i_scan_tail;
        end
        r_side   <= n_side;
        r_rem    <= n_rem;
        r_filled <= n_filled;
        r_rpt    <= n_rpt;
        r_out    <= n_out;
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

    a_idle_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (o_cmd.op == lome_pkg::OP_NONE))
        else $error("book changed while idle");

    a_fill_rescan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == lome_pkg::OP_FILL) |=> (r_state == lome_pkg::S_MSTART))
        else $error("fill not followed by rescan");

    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == lome_pkg::OP_FILL) |-> (o_cmd.qty != 32'd0) && w_push)
        else $error("empty fill or fill without trade");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k <= K_MAX))
        else $error("trade count over book size");

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int SLOTS = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DIR_ROWS = 22;
    localparam int RAND_ITEMS = 355;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    wire         o_ready;
    logic [1:0]  i_req_type;
    logic [31:0] i_seq_in;
    logic [31:0] i_order_ident;
    logic        i_buy_sell;
    logic signed [31:0] i_limit_price;
    logic [31:0] i_order_qty;
    wire         o_valid;
    logic        i_ready;
    wire         o_is_report;
    wire         o_last_item;
    wire  [31:0] o_subject_id;
    wire  [31:0] o_maker_ident;
    wire         o_side_out;
    wire  signed [31:0] o_price_out;
    wire  [31:0] o_qty_out;
    wire  [31:0] o_filled_total;
    wire  [2:0]  o_status_code;
    wire  [2:0]  o_reject_code;
    wire  [31:0] o_seq_out;
    wire  [31:0] o_trade_number;

    limit_order_matching_engine_top #(.BOOK_SLOTS(SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_seq_in(i_seq_in), .i_order_ident(i_order_ident),
        .i_buy_sell(i_buy_sell), .i_limit_price(i_limit_price), .i_order_qty(i_order_qty),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_is_report(o_is_report), .o_last_item(o_last_item),
        .o_subject_id(o_subject_id), .o_maker_ident(o_maker_ident),
        .o_side_out(o_side_out), .o_price_out(o_price_out), .o_qty_out(o_qty_out),
        .o_filled_total(o_filled_total), .o_status_code(o_status_code),
        .o_reject_code(o_reject_code), .o_seq_out(o_seq_out),
        .o_trade_number(o_trade_number)
    );

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] seq;
        logic [31:0] id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } t_order_cmd;

    // one directed row: command plus optional typed-in report
    typedef struct {
        t_order_cmd     cmd;
        bit             has_exp;
        lome_pkg::t_res exp;
    } t_dir_row;

    // --- predictor book: mirrors the block's resting orders ---
    logic [31:0] seq_counter;
    logic [31:0] trade_counter;
    bit          bk_live  [SLOTS];
    logic [31:0] bk_id    [SLOTS];
    logic        bk_side  [SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic [31:0] bk_rem   [SLOTS];
    logic [31:0] bk_fill  [SLOTS];
    int          bk_age   [SLOTS];

    lome_pkg::t_res expected_fills[$];
    int   mismatch_count;
    int   idle_cycles;
    bit   done_sending;
    bit   timed_out;
    bit   rx_free_run;
    bit   rx_hold;

    // recently used ids so cancels, modifies and duplicates hit the book
    logic [31:0] id_pool[$];

    function automatic lome_pkg::t_res mk_res(bit rep, logic [31:0] subj,
                                    logic [31:0] maker,
                                    logic side, logic [31:0] price, logic [31:0] qty,
                                    logic [31:0] filled, logic [2:0] st, logic [2:0] rj,
                                    logic [31:0] seq, logic [31:0] tnum);
        lome_pkg::t_res r;
        r.is_report = rep; r.last_item = rep; r.subject_id = subj;
        r.maker_ident = maker; r.side_out = side; r.price_out = price;
        r.qty_out = qty; r.filled_total = filled; r.status_code = st;
        r.reject_code = rj; r.seq_out = seq; r.trade_number = tnum;
        return r;
    endfunction

    // appends one expected result at the tail of the queue
    function automatic void expect_res(lome_pkg::t_res r);
        expected_fills.insert(expected_fills.size(), r);
    endfunction

    function automatic int book_lookup(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (bk_live[i] && bk_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void book_drop(int s);
        int r;
        r = bk_age[s];
        bk_live[s] = 0;
        for (int i = 0; i < SLOTS; i++)
            if (bk_live[i] && bk_age[i] > r) bk_age[i]--;
    endfunction

    // best resting order on one side: lowest ask, highest bid, oldest on ties
    function automatic int best_resting(logic sd);
        int b;
        bit better;
        b = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!bk_live[i] || bk_side[i] != sd) continue;
            if (b < 0) better = 1;
            else if (bk_price[i] == bk_price[b]) better = bk_age[i] < bk_age[b];
            else if (sd) better = bk_price[i] < bk_price[b];
            else better = bk_price[i] > bk_price[b];
            if (better) b = i;
        end
        return b;
    endfunction

    function automatic bit bad_price(logic [31:0] p);
        return p[31] || p == 0;
    endfunction

    function automatic void match_order(logic [31:0] seq, logic [31:0] id, logic side,
                                        logic [31:0] price, logic [31:0] qty);
        logic [31:0] rem, filled, q;
        logic [2:0] st, rj;
        int k, m, fs, n;
        rem = qty; filled = 0; k = 0; rj = lome_pkg::RJ_NONE; fs = -1;
        if (id == 0) begin
            expect_res(mk_res(1, id, 0, side, price, 0, 0, lome_pkg::ST_REJECTED,
                              lome_pkg::RJ_UNKNOWN, seq, 0));
            return;
        end
        if (bad_price(price)) begin
            expect_res(mk_res(1, id, 0, side, price, 0, 0, lome_pkg::ST_REJECTED,
                              lome_pkg::RJ_BAD_PRICE, seq, 0));
            return;
        end
        if (qty == 0) begin
            expect_res(mk_res(1, id, 0, side, price, 0, 0, lome_pkg::ST_REJECTED,
                              lome_pkg::RJ_BAD_QTY, seq, 0));
            return;
        end
        if (book_lookup(id) >= 0) begin
            expect_res(mk_res(1, id, 0, side, price, 0, 0, lome_pkg::ST_REJECTED,
                              lome_pkg::RJ_DUPLICATE, seq, 0));
            return;
        end
        while (rem > 0 && k < SLOTS) begin
            m = best_resting(!side);
            if (m < 0) break;
            if (side == 0 ? (price < bk_price[m]) : (price > bk_price[m])) break;
            q = (rem < bk_rem[m]) ? rem : bk_rem[m];
            bk_rem[m] -= q; bk_fill[m] += q; rem -= q; filled += q;
            expect_res(mk_res(0, id, bk_id[m], !side, bk_price[m], q, 0,
                              lome_pkg::ST_RESTING, lome_pkg::RJ_NONE, seq, trade_counter));
            k++;
            trade_counter++;
            if (bk_rem[m] == 0) book_drop(m);
        end
        if (rem == 0) st = lome_pkg::ST_FILLED;
        else begin
            for (int i = 0; i < SLOTS; i++)
                if (!bk_live[i]) begin fs = i; break; end
            if (fs < 0) begin
                st = lome_pkg::ST_REJECTED; rj = lome_pkg::RJ_BOOK_FULL;
            end else begin
                st = (k == 0) ? lome_pkg::ST_RESTING : lome_pkg::ST_PARTIAL;
                n = 0;
                for (int i = 0; i < SLOTS; i++) if (bk_live[i]) n++;
                bk_age[fs] = n; bk_live[fs] = 1; bk_id[fs] = id; bk_side[fs] = side;
                bk_price[fs] = price; bk_rem[fs] = rem; bk_fill[fs] = filled;
            end
        end
        expect_res(mk_res(1, id, 0, side, price, rem, filled, st, rj, seq, 0));
    endfunction

    // predicts every result of one accepted command
    function automatic void predict_command(t_order_cmd c);
        logic [31:0] seq;
        int s;
        logic sd;
        if (c.kind == lome_pkg::REQ_NONE) return;
        seq = c.seq;
        if (seq == 0) begin
            seq = seq_counter; seq_counter++;
        end else if (seq >= seq_counter) seq_counter = seq + 1;
        case (c.kind)
            lome_pkg::REQ_CREATE: match_order(seq, c.id, c.side, c.price, c.qty);
            lome_pkg::REQ_CANCEL: begin
                s = book_lookup(c.id);
                if (s < 0)
                    expect_res(mk_res(1, c.id, 0, 0, 0, 0, 0, lome_pkg::ST_REJECTED,
                                      lome_pkg::RJ_UNKNOWN, seq, 0));
                else begin
                    expect_res(mk_res(1, c.id, 0, bk_side[s], bk_price[s],
                                      0, bk_fill[s], lome_pkg::ST_CANCELLED,
                                      lome_pkg::RJ_NONE, seq, 0));
                    book_drop(s);
                end
            end
            default: begin
                s = book_lookup(c.id);
                if (bad_price(c.price))
                    expect_res(mk_res(1, c.id, 0, 0, c.price, 0, 0,
                                      lome_pkg::ST_REJECTED, lome_pkg::RJ_BAD_PRICE, seq, 0));
                else if (c.qty == 0)
                    expect_res(mk_res(1, c.id, 0, 0, c.price, 0, 0,
                                      lome_pkg::ST_REJECTED, lome_pkg::RJ_BAD_QTY, seq, 0));
                else if (s < 0)
                    expect_res(mk_res(1, c.id, 0, 0, c.price, 0, 0,
                                      lome_pkg::ST_REJECTED, lome_pkg::RJ_UNKNOWN, seq, 0));
                else begin
                    sd = bk_side[s];
                    book_drop(s);
                    match_order(seq, c.id, sd, c.price, c.qty);
                end
            end
        endcase
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // sender: drives one command and waits for the handshake
    task automatic send_command(t_order_cmd c);
        i_valid       <= 1;
        i_req_type    <= c.kind;
        i_seq_in      <= c.seq;
        i_order_ident <= c.id;
        i_buy_sell    <= c.side;
        i_limit_price <= c.price;
        i_order_qty   <= c.qty;
        do @(posedge i_clk); while (!o_ready);
        predict_command(c);
    endtask

    task automatic sender_gap(bit allow_idle);
        if (allow_idle && $urandom_range(99) < 11) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic t_order_cmd mk_cmd(logic [1:0] k, logic [31:0] seq, logic [31:0] id,
                                          logic sd, logic [31:0] p, logic [31:0] q);
        t_order_cmd c;
        c.kind = k; c.seq = seq; c.id = id; c.side = sd; c.price = p; c.qty = q;
        return c;
    endfunction

    // random command: mostly valid creates near a narrow price band so they cross
    function automatic t_order_cmd random_command();
        t_order_cmd c;
        int pick;
        pick = $urandom_range(99);
        c.seq   = ($urandom_range(9) == 0) ? $urandom() : 0;
        c.side  = $urandom_range(1);
        c.price = $urandom_range(95, 105);
        c.qty   = $urandom_range(1, 20);
        if (id_pool.size() > 0 && $urandom_range(3) != 0)
            c.id = id_pool[$urandom_range(id_pool.size() - 1)];
        else
            c.id = $urandom();
        if (pick < 60) c.kind = lome_pkg::REQ_CREATE;
        else if (pick < 75) c.kind = lome_pkg::REQ_CANCEL;
        else if (pick < 90) c.kind = lome_pkg::REQ_MODIFY;
        else begin
            // noise: extreme fields, bad values, unused type
            c.kind  = $urandom_range(3);
            c.price = $urandom();
            c.qty   = ($urandom_range(1) == 0) ? 0 : $urandom();
            if ($urandom_range(3) == 0) c.id = 0;
        end
        if ($urandom_range(40) == 0) c.qty = 32'hFFFF_FFFF;
        if (c.kind == lome_pkg::REQ_CREATE) begin
            id_pool.insert(id_pool.size(), c.id);
            if (id_pool.size() > 48) void'(id_pool.pop_front());
        end
        return c;
    endfunction

    t_dir_row dir_rows[DIR_ROWS];

    task automatic build_directed();
        for (int i = 0; i < DIR_ROWS; i++) dir_rows[i].has_exp = 0;
        // rejects after reset: seq numbers come from the counter starting at 1
        dir_rows[0].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 0, 1, 10, 5);
        dir_rows[0].has_exp = 1;
        dir_rows[0].exp = mk_res(1, 0, 0, 1, 10, 0, 0, lome_pkg::ST_REJECTED,
                                 lome_pkg::RJ_UNKNOWN, 1, 0);
        dir_rows[1].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 7, 0, 32'h8000_0000, 5);
        dir_rows[1].has_exp = 1;
        dir_rows[1].exp = mk_res(1, 7, 0, 0, 32'h8000_0000, 0, 0, lome_pkg::ST_REJECTED,
                                 lome_pkg::RJ_BAD_PRICE, 2, 0);
        dir_rows[2].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 7, 0, 0, 5);
        dir_rows[2].has_exp = 1;
        dir_rows[2].exp = mk_res(1, 7, 0, 0, 0, 0, 0, lome_pkg::ST_REJECTED,
                                 lome_pkg::RJ_BAD_PRICE, 3, 0);
        dir_rows[3].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 7, 1, 32'h7FFF_FFFF, 0);
        dir_rows[3].has_exp = 1;
        dir_rows[3].exp = mk_res(1, 7, 0, 1, 32'h7FFF_FFFF, 0, 0, lome_pkg::ST_REJECTED,
                                 lome_pkg::RJ_BAD_QTY, 4, 0);
        dir_rows[4].cmd = mk_cmd(lome_pkg::REQ_CANCEL, 0, 32'hFFFF_FFFF, 0, 0, 0);
        dir_rows[4].has_exp = 1;
        dir_rows[4].exp = mk_res(1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, lome_pkg::ST_REJECTED,
                                 lome_pkg::RJ_UNKNOWN, 5, 0);
        dir_rows[5].cmd = mk_cmd(lome_pkg::REQ_MODIFY, 0, 9, 0, 100, 3);
        dir_rows[5].has_exp = 1;
        dir_rows[5].exp = mk_res(1, 9, 0, 0, 100, 0, 0, lome_pkg::ST_REJECTED,
                                 lome_pkg::RJ_UNKNOWN, 6, 0);
        // unused request type: no result, no seq taken
        dir_rows[6].cmd = mk_cmd(lome_pkg::REQ_NONE, 0, 1, 1, 1, 1);
        // resting sells, then crossing buys and partial fills
        dir_rows[7].cmd  = mk_cmd(lome_pkg::REQ_CREATE, 0, 100, 1, 101, 10);
        dir_rows[8].cmd  = mk_cmd(lome_pkg::REQ_CREATE, 0, 101, 1, 100, 5);
        dir_rows[9].cmd  = mk_cmd(lome_pkg::REQ_CREATE, 0, 102, 1, 100, 5);
        dir_rows[10].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 100, 0, 50, 1);   // duplicate id
        dir_rows[11].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 200, 0, 101, 12); // sweeps three
        dir_rows[12].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 201, 0, 99, 4);
        dir_rows[13].cmd = mk_cmd(lome_pkg::REQ_MODIFY, 0, 201, 1, 32'hFFFF_FFFF, 4);
        dir_rows[14].cmd = mk_cmd(lome_pkg::REQ_MODIFY, 0, 201, 1, 99, 0);   // bad qty
        dir_rows[15].cmd = mk_cmd(lome_pkg::REQ_MODIFY, 0, 100, 0, 99, 20);  // re-enter
        dir_rows[16].cmd = mk_cmd(lome_pkg::REQ_CANCEL, 0, 100, 0, 0, 0);
        // given sequence numbers, including wrap of the counter
        dir_rows[17].cmd = mk_cmd(lome_pkg::REQ_CREATE, 32'hFFFF_FFFE, 300, 1, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF);
        dir_rows[18].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 301, 0, 1, 1);
        dir_rows[19].cmd = mk_cmd(lome_pkg::REQ_CREATE, 0, 302, 0, 1, 1);
        dir_rows[20].cmd = mk_cmd(lome_pkg::REQ_CANCEL, 5, 300, 0, 0, 0);
        dir_rows[21].cmd = mk_cmd(lome_pkg::REQ_CANCEL, 0, 301, 0, 0, 0);
    endtask

    // sender process: directed table, random part, book-full pressure
    initial begin
        t_order_cmd c;
        int n;
        i_rst_n = 0; i_valid = 0; i_req_type = lome_pkg::REQ_NONE; i_seq_in = 0;
        i_order_ident = 0; i_buy_sell = 0; i_limit_price = 0; i_order_qty = 0;
        done_sending = 0;
        seq_counter = 1; trade_counter = 1;
        for (int i = 0; i < SLOTS; i++) begin
            bk_live[i] = 0; bk_id[i] = 0; bk_side[i] = 0; bk_price[i] = 0;
            bk_rem[i] = 0; bk_fill[i] = 0; bk_age[i] = 0;
        end
        build_directed();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            n = expected_fills.size();
            send_command(dir_rows[r].cmd);
            // typed-in rows replace the predicted report with the hand value
            if (dir_rows[r].has_exp && expected_fills.size() == n + 1)
                expected_fills[n] = dir_rows[r].exp;
            sender_gap(1);
        end

        // fill the book with non-crossing orders to reach book full
        for (int i = 0; i < SLOTS + 3; i++) begin
            c = mk_cmd(lome_pkg::REQ_CREATE, 0, 1000 + i, 1, 5000 + i, 1);
            send_command(c);
        end
        c = mk_cmd(lome_pkg::REQ_CREATE, 0, 2000, 0, 4999, 3);   // buy that cannot rest
        send_command(c);
        c = mk_cmd(lome_pkg::REQ_CREATE, 0, 2001, 0, 5001, 5);   // two fills then rest
        send_command(c);
        for (int i = 0; i < SLOTS + 3; i++) begin
            c = mk_cmd(lome_pkg::REQ_CANCEL, 0, 1000 + i, 0, 0, 0);
            send_command(c);
        end
        c = mk_cmd(lome_pkg::REQ_CANCEL, 0, 2001, 0, 0, 0);
        send_command(c);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            c = random_command();
            send_command(c);
            sender_gap(!rx_free_run);
        end
        i_valid <= 0;
        done_sending = 1;
    end

    // receiver readiness: random stalls, a quiet stretch, one long hold-off
    initial begin
        i_ready = 0;
        rx_free_run = 0;
        rx_hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold) i_ready <= 0;
            else if (rx_free_run) i_ready <= 1;
            else i_ready <= ($urandom_range(99) >= 11);
        end
    end

    initial begin
        @(posedge i_rst_n);
        repeat (3000) @(posedge i_clk);
        rx_hold = 1;
        repeat (600) @(posedge i_clk);
        rx_hold = 0;
        repeat (2000) @(posedge i_clk);
        rx_free_run = 1;
        repeat (4000) @(posedge i_clk);
        rx_free_run = 0;
    end

    // checker: compares each result with the oldest expectation
    always @(posedge i_clk) begin
        lome_pkg::t_res want;
        lome_pkg::t_res got;
        if (i_rst_n && o_valid && i_ready) begin
            got = mk_res(o_is_report, o_subject_id, o_maker_ident, o_side_out,
                         o_price_out, o_qty_out, o_filled_total, o_status_code,
                         o_reject_code, o_seq_out, o_trade_number);
            got.last_item = o_last_item;
            if (expected_fills.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %p", got);
            end else begin
                want = expected_fills.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || rx_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
        timed_out = 0;
        wait (done_sending);
        while (expected_fills.size() != 0 && idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        if (expected_fills.size() != 0) timed_out = 1;
        // a trailing stray result would show up within one command time
        repeat (4 * (SLOTS + 3)) @(posedge i_clk);
        if (timed_out || mismatch_count != 0) begin
            $display("CHECKS FAILED");
        end else begin
            $display("ALL CHECKS PASSED");
        end
        $finish;
    end

    // hard stop if the block hangs before the end of stimulus
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT && !done_sending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
